// ===== rtl/core/sld_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// sld_pkg: shared types and constants for the sync/length deframer
// Phase codes, configuration register indexes, widths and reset values.
// ----------------------------------------------------------------------------
package sld_pkg;

  // Widths fixed by the stream format
  localparam int unsigned BYTE_W      = 8;
  localparam int unsigned SYNC_W      = 32;
  localparam int unsigned HDR_LEN_W   = 32;
  localparam int unsigned MAX_W       = 23;
  localparam int unsigned CFG_IDX_W   = 4;
  localparam int unsigned CFG_DATA_W  = 32;

  // Default payload length width
  localparam int unsigned LEN_BITS_DEF = 23;

  // Header bytes added to the payload length for the total-length check
  localparam int unsigned HDR_BYTES = 8;

  // Register reset values
  localparam logic [SYNC_W-1:0] SYNC_WORD_RST     = 32'hEAEC_FBFD;
  localparam logic [MAX_W-1:0]  MAX_TOTAL_LEN_RST = 23'(1024 * 1024 * 5);

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_SYNC_WORD     = 4'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_TOTAL_LEN = 4'd1;

  // Parser phase
  typedef enum logic [1:0] {
    PH_HUNT = 2'd0,
    PH_LEN  = 2'd1,
    PH_DATA = 2'd2
  } phase_e;

endpackage : sld_pkg
`default_nettype wire

// ===== rtl/core/sld_in_stage.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// sld_in_stage: input byte register
// Captures one received byte per transaction and holds it until the parser
// consumes it; takes a new byte in the same cycle the held one is consumed.
// ----------------------------------------------------------------------------
module sld_in_stage (
  input  wire logic                       clk_i,
  input  wire logic                       rst_ni,
  input  wire logic                       in_valid_i,
  output logic                            in_ready_o,
  input  wire logic [sld_pkg::BYTE_W-1:0] in_byte_i,
  input  wire logic                       consume_i,
  output logic                            held_valid_o,
  output logic [sld_pkg::BYTE_W-1:0]      held_byte_o
);

  logic                       valid_q, valid_d;
  logic [sld_pkg::BYTE_W-1:0] byte_q;
  logic                       take;

  // Accept when empty or when the held byte leaves this cycle
  assign in_ready_o = !valid_q || consume_i;
  assign take       = in_valid_i && in_ready_o;

  always_comb begin
    valid_d = valid_q;
    if (take) begin
      valid_d = 1'b1;
    end else if (consume_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  // Hold the byte payload
  always_ff @(posedge clk_i) begin
    if (take) begin
      byte_q <= in_byte_i;
    end
  end

  assign held_valid_o = valid_q;
  assign held_byte_o  = byte_q;

endmodule : sld_in_stage
`default_nettype wire

// ===== rtl/core/sld_parse.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// sld_parse: frame parser
// Holds the configuration registers and the hunt/length/data state. Each
// consumed byte advances the state once; payload bytes produce a result.
// ----------------------------------------------------------------------------
module sld_parse #(
  parameter int unsigned LEN_BITS = sld_pkg::LEN_BITS_DEF
) (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  input  wire logic                           cfg_valid_i,
  input  wire logic [sld_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input  wire logic [sld_pkg::CFG_DATA_W-1:0] cfg_data_i,
  input  wire logic                           step_i,
  input  wire logic [sld_pkg::BYTE_W-1:0]     byte_i,
  output logic                                res_valid_o,
  output logic [sld_pkg::BYTE_W-1:0]          res_byte_o,
  output logic                                res_first_o,
  output logic                                res_last_o,
  output logic [LEN_BITS-1:0]                 res_len_o
);

  localparam int unsigned SUM_W = sld_pkg::HDR_LEN_W + 1;

  // Configuration registers
  logic [sld_pkg::SYNC_W-1:0] sync_word_q;
  logic [sld_pkg::MAX_W-1:0]  max_total_q;

  // Parser state
  sld_pkg::phase_e               phase_q, phase_d;
  logic [sld_pkg::SYNC_W-1:0]    window_q, window_d;
  logic [23:0]                   gather_q, gather_d;
  logic [1:0]                    cnt_q, cnt_d;
  logic [LEN_BITS-1:0]           left_q, left_d;
  logic [LEN_BITS-1:0]           flen_q, flen_d;

  logic [sld_pkg::SYNC_W-1:0]    window_shift;
  logic [sld_pkg::HDR_LEN_W-1:0] len_full;
  logic [SUM_W-1:0]              len_total;
  logic                          len_bad;
  logic                          last_byte;

  // Write configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sync_word_q <= sld_pkg::SYNC_WORD_RST;
      max_total_q <= sld_pkg::MAX_TOTAL_LEN_RST;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        sld_pkg::CFG_SYNC_WORD:     sync_word_q <= cfg_data_i;
        sld_pkg::CFG_MAX_TOTAL_LEN: max_total_q <= cfg_data_i[sld_pkg::MAX_W-1:0];
        default: ;
      endcase
    end
  end

  // Header and payload arithmetic
  assign window_shift = {window_q[sld_pkg::SYNC_W-9:0], byte_i};
  assign len_full     = {byte_i, gather_q};
  assign len_total    = {1'b0, len_full} + SUM_W'(sld_pkg::HDR_BYTES);
  assign len_bad      = len_full[sld_pkg::HDR_LEN_W-1] || (len_full == '0) ||
                        (len_total >= {{(SUM_W - sld_pkg::MAX_W){1'b0}}, max_total_q});
  assign last_byte    = (left_q[LEN_BITS-1:1] == '0);

  // Next state and result
  always_comb begin
    phase_d     = phase_q;
    window_d    = window_q;
    gather_d    = gather_q;
    cnt_d       = cnt_q;
    left_d      = left_q;
    flen_d      = flen_q;
    res_valid_o = 1'b0;
    res_byte_o  = byte_i;
    res_first_o = (left_q == flen_q);
    res_last_o  = last_byte;
    res_len_o   = flen_q;

    if (step_i) begin
      unique case (phase_q)
        sld_pkg::PH_LEN: begin
          if (cnt_q == 2'd3) begin
            if (len_bad) begin
              // Drop the frame and hunt with a cleared window
              phase_d  = sld_pkg::PH_HUNT;
              window_d = '0;
              gather_d = '0;
              cnt_d    = '0;
              left_d   = '0;
            end else begin
              phase_d = sld_pkg::PH_DATA;
              left_d  = len_full[LEN_BITS-1:0];
              flen_d  = len_full[LEN_BITS-1:0];
              cnt_d   = '0;
            end
          end else begin
            // Gather length bytes, least significant first
            case (cnt_q)
              2'd0:    gather_d[7:0]   = byte_i;
              2'd1:    gather_d[15:8]  = byte_i;
              default: gather_d[23:16] = byte_i;
            endcase
            cnt_d = cnt_q + 2'd1;
          end
        end

        sld_pkg::PH_DATA: begin
          res_valid_o = 1'b1;
          if (last_byte) begin
            phase_d  = sld_pkg::PH_HUNT;
            window_d = '0;
            gather_d = '0;
            cnt_d    = '0;
            left_d   = '0;
          end else begin
            left_d = left_q - LEN_BITS'(1);
          end
        end

        default: begin
          // Hunt: shift the window, match once it holds four bytes
          phase_d  = sld_pkg::PH_HUNT;
          window_d = window_shift;
          if ((cnt_q == 2'd3) && (window_shift == sync_word_q)) begin
            phase_d  = sld_pkg::PH_LEN;
            gather_d = '0;
            cnt_d    = '0;
          end else if (cnt_q != 2'd3) begin
            cnt_d = cnt_q + 2'd1;
          end
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q  <= sld_pkg::PH_HUNT;
      window_q <= '0;
      gather_q <= '0;
      cnt_q    <= '0;
      left_q   <= '0;
      flen_q   <= '0;
    end else begin
      phase_q  <= phase_d;
      window_q <= window_d;
      gather_q <= gather_d;
      cnt_q    <= cnt_d;
      left_q   <= left_d;
      flen_q   <= flen_d;
    end
  end

endmodule : sld_parse
`default_nettype wire

// ===== rtl/core/sld_out_stage.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// sld_out_stage: result register
// Holds one payload byte with its marks and length until the receiver takes
// the transaction; reports when a new result may be loaded.
// ----------------------------------------------------------------------------
module sld_out_stage #(
  parameter int unsigned LEN_BITS = sld_pkg::LEN_BITS_DEF
) (
  input  wire logic                       clk_i,
  input  wire logic                       rst_ni,
  input  wire logic                       load_i,
  input  wire logic [sld_pkg::BYTE_W-1:0] byte_i,
  input  wire logic                       first_i,
  input  wire logic                       last_i,
  input  wire logic [LEN_BITS-1:0]        len_i,
  output logic                            free_o,
  output logic                            out_valid_o,
  input  wire logic                       out_ready_i,
  output logic [sld_pkg::BYTE_W-1:0]      payload_byte_o,
  output logic                            first_flag_o,
  output logic                            last_flag_o,
  output logic [LEN_BITS-1:0]             payload_length_o
);

  logic                       valid_q, valid_d;
  logic [sld_pkg::BYTE_W-1:0] byte_q;
  logic                       first_q;
  logic                       last_q;
  logic [LEN_BITS-1:0]        len_q;

  // Slot is free when empty or drained this cycle
  assign free_o = !valid_q || out_ready_i;

  always_comb begin
    valid_d = valid_q;
    if (load_i) begin
      valid_d = 1'b1;
    end else if (out_ready_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  // Hold the result payload
  always_ff @(posedge clk_i) begin
    if (load_i) begin
      byte_q  <= byte_i;
      first_q <= first_i;
      last_q  <= last_i;
      len_q   <= len_i;
    end
  end

  assign out_valid_o      = valid_q;
  assign payload_byte_o   = byte_q;
  assign first_flag_o     = first_q;
  assign last_flag_o      = last_q;
  assign payload_length_o = len_q;

endmodule : sld_out_stage
`default_nettype wire

// ===== rtl/core/sync_length_deframer.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// sync_length_deframer: sync-word / length-prefixed frame extractor
// Usage:
//   Input channel (in_valid_i/in_ready_o/in_byte_i) carries the raw byte
//   stream, one byte per transaction. The block hunts for the sync word,
//   reads a 4-byte little-endian signed length, and passes each payload byte
//   out on the output channel (out_valid_o/out_ready_i) with first/last marks
//   and the frame's payload length. Sync, length and junk bytes are dropped.
//   Configuration channel (cfg_valid_i/cfg_ready_o, cfg_index_i, cfg_data_i)
//   writes index 0 = sync word, index 1 = max total frame length; write it
//   only while the block is idle. cfg_ready_o is always high.
//   Path: a payload byte passes the input register, then the result
//   register, before out_valid_o rises.
//   Throughput: one byte per cycle while the receiver does not stall; the
//   parser advances its state once per byte, between the two registers.
//   Reset: registers return to their defaults and the parser hunts with a
//   cleared window; no result is pending.
//   Receiver stall: the result register holds; the input register holds at
//   most one more byte, then in_ready_o drops until the result is taken.
// ----------------------------------------------------------------------------
module sync_length_deframer #(
  parameter int unsigned LEN_BITS = sld_pkg::LEN_BITS_DEF
) (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  input  wire logic                           cfg_valid_i,
  output logic                                cfg_ready_o,
  input  wire logic [sld_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input  wire logic [sld_pkg::CFG_DATA_W-1:0] cfg_data_i,
  input  wire logic                           in_valid_i,
  output logic                                in_ready_o,
  input  wire logic [sld_pkg::BYTE_W-1:0]     in_byte_i,
  output logic                                out_valid_o,
  input  wire logic                           out_ready_i,
  output logic [sld_pkg::BYTE_W-1:0]          payload_byte_o,
  output logic                                first_flag_o,
  output logic                                last_flag_o,
  output logic [LEN_BITS-1:0]                 payload_length_o
);

  logic                       held_valid;
  logic [sld_pkg::BYTE_W-1:0] held_byte;
  logic                       out_free;
  logic                       step;
  logic                       res_valid;
  logic [sld_pkg::BYTE_W-1:0] res_byte;
  logic                       res_first;
  logic                       res_last;
  logic [LEN_BITS-1:0]        res_len;

  assign cfg_ready_o = 1'b1;

  // Advance the parser when a byte is held and the result slot is free
  assign step = held_valid && out_free;

  sld_in_stage u_in_stage (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .in_byte_i    (in_byte_i),
    .consume_i    (step),
    .held_valid_o (held_valid),
    .held_byte_o  (held_byte)
  );

  sld_parse #(
    .LEN_BITS (LEN_BITS)
  ) u_parse (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .step_i      (step),
    .byte_i      (held_byte),
    .res_valid_o (res_valid),
    .res_byte_o  (res_byte),
    .res_first_o (res_first),
    .res_last_o  (res_last),
    .res_len_o   (res_len)
  );

  sld_out_stage #(
    .LEN_BITS (LEN_BITS)
  ) u_out_stage (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .load_i           (res_valid),
    .byte_i           (res_byte),
    .first_i          (res_first),
    .last_i           (res_last),
    .len_i            (res_len),
    .free_o           (out_free),
    .out_valid_o      (out_valid_o),
    .out_ready_i      (out_ready_i),
    .payload_byte_o   (payload_byte_o),
    .first_flag_o     (first_flag_o),
    .last_flag_o      (last_flag_o),
    .payload_length_o (payload_length_o)
  );

endmodule : sync_length_deframer
`default_nettype wire
